FILE: hw/rtl/msjd_pkg.sv
package msjd_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

	localparam int ARRIVE_W = 24;
	localparam int SERVICE_W = 16;
	localparam int CFG_W = 5;
	localparam int SRV_IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int SUM_W = 48;

	typedef logic [IDX_W-1:0] msjd_idx_t;

	typedef struct packed {
		logic load;
		logic step;
		logic calc;
		logic commit;
	} msjd_cmd_t;

	typedef struct packed {
		logic scan_last;
	} msjd_sts_t;

endpackage

FILE: hw/rtl/msjd_ctrl.sv
module msjd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  msjd_pkg::msjd_sts_t sts,
	output msjd_pkg::msjd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_SCAN);
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.commit = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// output register holds a result until its transfer
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/msjd_dpath.sv
module msjd_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  msjd_pkg::msjd_cmd_t                  cmd,
	output msjd_pkg::msjd_sts_t                  sts,
	input  logic                                 cfg_valid,
	input  logic [msjd_pkg::CFG_W-1:0]           cfg_data,
	input  logic [msjd_pkg::ARRIVE_W-1:0]        arrive_time,
	input  logic [msjd_pkg::SERVICE_W-1:0]       service_time,
	output logic [msjd_pkg::SRV_IDX_W-1:0]       server_index,
	output logic [msjd_pkg::TIME_W-1:0]          wait_ticks,
	output logic [msjd_pkg::SUM_W-1:0]           total_wait,
	output logic signed [msjd_pkg::TIME_W-1:0]   max_wait,
	output logic [msjd_pkg::TIME_W-1:0]          latest_finish,
	output logic [msjd_pkg::TIME_W-1:0]          jobs_seen
);

	localparam int TW = msjd_pkg::TIME_W;
	localparam int SW = msjd_pkg::SUM_W;

	logic [msjd_pkg::CFG_W-1:0]     servers_q;
	msjd_pkg::msjd_idx_t            last_idx;

	logic [TW-1:0]                  finish_q [msjd_pkg::MAX_SERVERS];
	logic [msjd_pkg::MAX_SERVERS-1:0] used_q;

	logic [msjd_pkg::ARRIVE_W-1:0]  arrive_q;
	logic [msjd_pkg::SERVICE_W-1:0] service_q;
	msjd_pkg::msjd_idx_t            j_q;

	logic                           unused_found_q;
	msjd_pkg::msjd_idx_t            unused_idx_q;
	logic                           le_found_q;
	msjd_pkg::msjd_idx_t            le_idx_q;
	msjd_pkg::msjd_idx_t            min_idx_q;
	logic [TW-1:0]                  min_val_q;

	msjd_pkg::msjd_idx_t            pick_q;
	logic [TW-1:0]                  wait_q;
	logic [TW-1:0]                  new_finish_q;
	logic                           waited_q;

	logic [SW-1:0]                  wait_sum_q;
	logic signed [TW-1:0]           wait_peak_q;
	logic [TW-1:0]                  finish_peak_q;
	logic [TW-1:0]                  job_count_q;

	logic [TW-1:0]                  cur_finish;
	logic [TW-1:0]                  arrive_ext;

	msjd_pkg::msjd_idx_t            calc_pick;
	logic [TW-1:0]                  calc_base;
	logic [TW-1:0]                  calc_wait;
	logic                           calc_waited;
	logic [TW:0]                    calc_sum;

	logic [SW:0]                    sum_raw;
	logic [SW-1:0]                  sum_next;
	logic signed [TW-1:0]           wait_clip;
	logic signed [TW-1:0]           peak_next;
	logic [TW-1:0]                  fpeak_next;
	logic [TW-1:0]                  count_next;

	// active server count, zero taken as one and clamped to the array size
	always_comb begin
		if (servers_q == '0) begin
			last_idx = '0;
		end else if (int'(servers_q) > msjd_pkg::MAX_SERVERS) begin
			last_idx = msjd_pkg::IDX_W'(msjd_pkg::MAX_SERVERS - 1);
		end else begin
			last_idx = msjd_pkg::IDX_W'(servers_q - 5'd1);
		end
	end

	assign sts.scan_last = (j_q == last_idx);

	assign cur_finish = finish_q[j_q];
	assign arrive_ext = {{(TW - msjd_pkg::ARRIVE_W){1'b0}}, arrive_q};

	always_comb begin
		if (unused_found_q) begin
			calc_pick   = unused_idx_q;
			calc_base   = arrive_ext;
			calc_wait   = '0;
			calc_waited = 1'b0;
		end else if (le_found_q) begin
			calc_pick   = le_idx_q;
			calc_base   = arrive_ext;
			calc_wait   = '0;
			calc_waited = 1'b0;
		end else begin
			calc_pick   = min_idx_q;
			calc_base   = min_val_q;
			calc_wait   = min_val_q - arrive_ext;
			calc_waited = 1'b1;
		end
		calc_sum = {1'b0, calc_base} + {{(TW + 1 - msjd_pkg::SERVICE_W){1'b0}}, service_q};
	end

	always_comb begin
		sum_raw    = {1'b0, wait_sum_q} + {{(SW + 1 - TW){1'b0}}, wait_q};
		sum_next   = wait_sum_q;
		peak_next  = wait_peak_q;
		wait_clip  = wait_q[TW-1] ? {1'b0, {(TW - 1){1'b1}}} : $signed(wait_q);
		if (waited_q) begin
			sum_next = sum_raw[SW] ? {SW{1'b1}} : sum_raw[SW-1:0];
			if (wait_clip > wait_peak_q) peak_next = wait_clip;
		end
		fpeak_next = (new_finish_q > finish_peak_q) ? new_finish_q : finish_peak_q;
		count_next = job_count_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servers_q     <= 5'd1;
			used_q        <= '0;
			wait_sum_q    <= '0;
			wait_peak_q   <= '1;
			finish_peak_q <= '0;
			job_count_q   <= '0;
		end else begin
			if (cfg_valid) servers_q <= cfg_data;
			if (cmd.commit) begin
				used_q[pick_q] <= 1'b1;
				wait_sum_q     <= sum_next;
				wait_peak_q    <= peak_next;
				finish_peak_q  <= fpeak_next;
				job_count_q    <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arrive_q       <= arrive_time;
			service_q      <= service_time;
			j_q            <= '0;
			unused_found_q <= 1'b0;
			le_found_q     <= 1'b0;
		end
		if (cmd.step) begin
			if (!unused_found_q && !used_q[j_q]) begin
				unused_found_q <= 1'b1;
				unused_idx_q   <= j_q;
			end
			if (!le_found_q && (cur_finish <= arrive_ext)) begin
				le_found_q <= 1'b1;
				le_idx_q   <= j_q;
			end
			if ((j_q == '0) || (cur_finish < min_val_q)) begin
				min_val_q <= cur_finish;
				min_idx_q <= j_q;
			end
			j_q <= j_q + 1'b1;
		end
		if (cmd.calc) begin
			pick_q       <= calc_pick;
			wait_q       <= calc_wait;
			waited_q     <= calc_waited;
			new_finish_q <= calc_sum[TW] ? {TW{1'b1}} : calc_sum[TW-1:0];
		end
		if (cmd.commit) begin
			finish_q[pick_q] <= new_finish_q;
			server_index     <= msjd_pkg::SRV_IDX_W'(pick_q);
			wait_ticks       <= wait_q;
			total_wait       <= sum_next;
			max_wait         <= peak_next;
			latest_finish    <= fpeak_next;
			jobs_seen        <= count_next;
		end
	end

endmodule

FILE: hw/rtl/multi_server_job_dispatcher_unit.sv
// a job passes the server scan, the calc state and the commit state; commit registers its result
// in_stall holds a new job off until the previous one commits; the scan
//   compares one server finish time per cycle
// a finished result waits in the output register while the next job is scanned
// reset: asynchronous active low, clears used flags and statistics, servers in use is 1
module multi_server_job_dispatcher_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msjd_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [msjd_pkg::ARRIVE_W-1:0]        arrive_time,
	input  logic [msjd_pkg::SERVICE_W-1:0]       service_time,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [msjd_pkg::SRV_IDX_W-1:0]       server_index,
	output logic [msjd_pkg::TIME_W-1:0]          wait_ticks,
	output logic [msjd_pkg::SUM_W-1:0]           total_wait,
	output logic signed [msjd_pkg::TIME_W-1:0]   max_wait,
	output logic [msjd_pkg::TIME_W-1:0]          latest_finish,
	output logic [msjd_pkg::TIME_W-1:0]          jobs_seen
);

	msjd_pkg::msjd_cmd_t cmd;
	msjd_pkg::msjd_sts_t sts;

	assign cfg_ready = 1'b1;

	msjd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	msjd_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.arrive_time   (arrive_time),
		.service_time  (service_time),
		.server_index  (server_index),
		.wait_ticks    (wait_ticks),
		.total_wait    (total_wait),
		.max_wait      (max_wait),
		.latest_finish (latest_finish),
		.jobs_seen     (jobs_seen)
	);

endmodule

FILE: bench/multi_server_job_dispatcher_unit_test.sv
module multi_server_job_dispatcher_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SERVERS = msjd_pkg::MAX_SERVERS;
	localparam int CFG_W = msjd_pkg::CFG_W;
	localparam int ARRIVE_W = msjd_pkg::ARRIVE_W;
	localparam int SERVICE_W = msjd_pkg::SERVICE_W;
	localparam int SRV_IDX_W = msjd_pkg::SRV_IDX_W;
	localparam int TIME_W = msjd_pkg::TIME_W;
	localparam int SUM_W = msjd_pkg::SUM_W;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_JOBS = 71;
	localparam int QUEUE_JOBS = 20;
	localparam logic [SUM_W-1:0] SUM_TOP = '1;
	localparam logic [TIME_W-1:0] FINISH_TOP = '1;
	localparam longint PEAK_TOP = 64'h7FFF_FFFF;

	typedef struct packed {
		logic [SRV_IDX_W-1:0] srv;
		logic [TIME_W-1:0] waited;
		logic [SUM_W-1:0] sum;
		logic [TIME_W-1:0] peak;
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] jobs;
	} job_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ARRIVE_W-1:0] arrive_time = '0;
	logic [SERVICE_W-1:0] service_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SRV_IDX_W-1:0] server_index;
	logic [TIME_W-1:0] wait_ticks;
	logic [SUM_W-1:0] total_wait;
	logic signed [TIME_W-1:0] max_wait;
	logic [TIME_W-1:0] latest_finish;
	logic [TIME_W-1:0] jobs_seen;

	// dispatcher state as predicted
	logic [TIME_W-1:0] srv_finish [MAX_SERVERS];
	bit srv_used [MAX_SERVERS];
	logic [SUM_W-1:0] wait_sum;
	longint wait_peak;
	logic [TIME_W-1:0] finish_peak;
	logic [TIME_W-1:0] job_count;
	logic [CFG_W-1:0] srv_count;

	job_result_t pending_results [$];

	int send_idle_pct = 22;
	int recv_idle_pct = 69;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int jobs_sent = 0;
	int cfg_writes = 0;
	int opened_jobs = 0;
	int reused_jobs = 0;
	int waited_jobs = 0;

	multi_server_job_dispatcher_unit dut (.*);

	always #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] sat_finish(input logic [TIME_W-1:0] base,
			input logic [SERVICE_W-1:0] s);
		logic [TIME_W:0] t;
		t = (TIME_W + 1)'(base) + (TIME_W + 1)'(s);
		return t[TIME_W] ? FINISH_TOP : t[TIME_W-1:0];
	endfunction

	function automatic job_result_t dispatch_job(input logic [ARRIVE_W-1:0] a,
			input logic [SERVICE_W-1:0] s);
		int n;
		int pick;
		bit hit;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] waited;
		logic [SUM_W:0] sum_next;
		longint w_peak;
		job_result_t r;
		n = (srv_count == 0) ? 1 : (srv_count > MAX_SERVERS) ? MAX_SERVERS : srv_count;
		arr = TIME_W'(a);
		pick = 0;
		hit = 1'b0;
		waited = '0;
		for (int j = 0; j < n && !hit; j++) begin
			if (!srv_used[j]) begin
				pick = j;
				hit = 1'b1;
			end
		end
		if (hit) begin
			srv_used[pick] = 1'b1;
			srv_finish[pick] = sat_finish(arr, s);
			opened_jobs++;
		end else begin
			for (int j = 0; j < n && !hit; j++) begin
				if (srv_finish[j] <= arr) begin
					pick = j;
					hit = 1'b1;
				end
			end
			if (hit) begin
				srv_finish[pick] = sat_finish(arr, s);
				reused_jobs++;
			end else begin
				for (int j = 1; j < n; j++) begin
					if (srv_finish[j] < srv_finish[pick])
						pick = j;
				end
				waited = srv_finish[pick] - arr;
				w_peak = longint'(waited);
				if (w_peak > PEAK_TOP)
					w_peak = PEAK_TOP;
				if (w_peak > wait_peak)
					wait_peak = w_peak;
				sum_next = (SUM_W + 1)'(wait_sum) + (SUM_W + 1)'(waited);
				wait_sum = (sum_next > SUM_TOP) ? SUM_TOP : sum_next[SUM_W-1:0];
				srv_finish[pick] = sat_finish(srv_finish[pick], s);
				waited_jobs++;
			end
		end
		if (srv_finish[pick] > finish_peak)
			finish_peak = srv_finish[pick];
		job_count = job_count + 1;
		r.srv = pick[SRV_IDX_W-1:0];
		r.waited = waited;
		r.sum = wait_sum;
		r.peak = wait_peak[TIME_W-1:0];
		r.fin = finish_peak;
		r.jobs = job_count;
		return r;
	endfunction

	task automatic send_job(input logic [ARRIVE_W-1:0] a, input logic [SERVICE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		arrive_time <= a;
		service_time <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(dispatch_job(a, s));
		jobs_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_server_count(input logic [CFG_W-1:0] v);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		srv_count = v;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new server, free server and waiting job all on one server
	task automatic test_single_server();
		write_server_count(5'd1);
		send_job(24'd0, 16'd0);
		send_job(24'd0, 16'hFFFF);
		send_job(24'd5, 16'd1);
	endtask

	task automatic test_count_zero();
		write_server_count(5'd0);
		send_job(24'd3, 16'h8000);
	endtask

	// count above the server array, then an arrival earlier than the last one
	task automatic test_count_clamp();
		write_server_count(5'd31);
		for (int k = 1; k < MAX_SERVERS; k++)
			send_job(24'hFFFFFF, SERVICE_W'(16'hFFFF - k));
		send_job(24'd0, 16'd7);
	endtask

	task automatic test_backpressure();
		write_server_count(5'd4);
		hold_req = 1'b1;
		for (int k = 0; k < 12; k++)
			send_job(ARRIVE_W'(24'h100 + k), SERVICE_W'($urandom_range(300)));
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct);
		int unsigned now;
		int unsigned span;
		int n_eff;
		int roll;
		logic [CFG_W-1:0] count;
		logic [SERVICE_W-1:0] svc_cap;
		logic [SERVICE_W-1:0] s;
		logic [ARRIVE_W-1:0] a;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: count = CFG_W'(MAX_SERVERS);
				1: count = 5'd1;
				2: count = 5'd0;
				3: count = 5'd31;
				default: count = CFG_W'($urandom_range(1, 31));
			endcase
			write_server_count(count);
			n_eff = (count == 0) ? 1 : (count > MAX_SERVERS) ? MAX_SERVERS : count;
			case ($urandom_range(3))
				0: svc_cap = 16'h000F;
				1: svc_cap = 16'h00FF;
				2: svc_cap = 16'h0FFF;
				default: svc_cap = 16'hFFFF;
			endcase
			now = ($urandom_range(3) == 0) ? 24'hFF0000 : $urandom_range(4095);
			span = 2 * svc_cap / n_eff + 1;
			for (int k = 0; k < PHASE_JOBS; k++) begin
				roll = $urandom_range(99);
				if (roll < 8)
					s = '0;
				else if (roll < 16)
					s = '1;
				else
					s = SERVICE_W'($urandom_range(svc_cap));
				if ($urandom_range(99) < 5)
					a = ARRIVE_W'($urandom);
				else
					a = ARRIVE_W'(now);
				now = now + $urandom_range(span);
				if (now > 24'hFFFFFF)
					now = $urandom_range(255);
				send_job(a, s);
			end
		end
	endtask

	// one server fed back to back so every job waits behind the previous one
	task automatic test_queue_buildup();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_server_count(5'd1);
		repeat (QUEUE_JOBS)
			send_job(24'd0, 16'hFFFF);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		job_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t: server %0d wait %0d",
						$time, server_index, wait_ticks);
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (exp_r.srv !== server_index || exp_r.waited !== wait_ticks ||
						exp_r.sum !== total_wait || exp_r.peak !== max_wait ||
						exp_r.fin !== latest_finish || exp_r.jobs !== jobs_seen) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $time);
						$display("  exp: srv %0d wait %0d sum %0d peak %0d fin %0d jobs %0d",
							exp_r.srv, exp_r.waited, exp_r.sum, $signed(exp_r.peak),
							exp_r.fin, exp_r.jobs);
						$display("  got: srv %0d wait %0d sum %0d peak %0d fin %0d jobs %0d",
							server_index, wait_ticks, total_wait, max_wait,
							latest_finish, jobs_seen);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		foreach (srv_finish[j]) begin
			srv_finish[j] = '0;
			srv_used[j] = 1'b0;
		end
		wait_sum = '0;
		wait_peak = -1;
		finish_peak = '0;
		job_count = '0;
		srv_count = 5'd1;
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_server();
		test_count_zero();
		test_count_clamp();
		test_random_traffic(22, 69);
		test_backpressure();
		test_random_traffic(69, 22);
		test_random_traffic(0, 0);
		test_queue_buildup();
		wait_for_results();
		repeat (25)
			@(negedge clk);
		if (pending_results.size() != 0) begin
			mismatches += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("covered %0d jobs across %0d server count writes", jobs_sent, cfg_writes);
		$display("%0d opened a server, %0d reused a free one, %0d waited",
			opened_jobs, reused_jobs, waited_jobs);
		$display("%0d results checked, %0d mismatches, final total wait %0d, peak wait %0d",
			results_checked, mismatches, wait_sum, wait_peak);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
